/* rtl/core/shss_pkg.sv */
// shared types, codes and constants of the sensor health and sample scheduler
`timescale 1ns / 1ps

package shss_pkg;

  // health codes
  localparam logic [1:0] H_READY    = 2'd0;
  localparam logic [1:0] H_DEGRADED = 2'd1;
  localparam logic [1:0] H_MISSING  = 2'd2;
  localparam logic [1:0] H_UNPROBED = 2'd3;

  // action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_INIT    = 2'd1;
  localparam logic [1:0] ACT_TRIGGER = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TWO_PHASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPROBE_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESH  = 3'd5;

  localparam int US_PER_MS = 1000;

  // periods are kept in microseconds: ms field width plus ten bits for the scale
  localparam int SAMPLE_US_W  = 26;
  localparam int CONV_US_W    = 20;
  localparam int FIRST_US_W   = 26;
  localparam int REPROBE_US_W = 30;
  localparam int US_W         = 30;

  localparam int RST_SAMPLE_MS  = 1000;
  localparam int RST_CONV_MS    = 80;
  localparam int RST_FIRST_MS   = 0;
  localparam int RST_REPROBE_MS = 5000;
  localparam logic [7:0] RST_FAIL_THRESH = 8'd3;

  localparam logic [SAMPLE_US_W-1:0]  RST_SAMPLE_US  = SAMPLE_US_W'(RST_SAMPLE_MS * US_PER_MS);
  localparam logic [CONV_US_W-1:0]    RST_CONV_US    = CONV_US_W'(RST_CONV_MS * US_PER_MS);
  localparam logic [FIRST_US_W-1:0]   RST_FIRST_US   = FIRST_US_W'(RST_FIRST_MS * US_PER_MS);
  localparam logic [REPROBE_US_W-1:0] RST_REPROBE_US = REPROBE_US_W'(RST_REPROBE_MS * US_PER_MS);

  // fixed part of the result item ahead of the failure counters
  localparam int RES_FLAGS_W = 10;
  localparam int TOTAL_W     = 32;

endpackage

/* rtl/core/sensor_health_sample_scheduler_core.sv */
// top level of the sensor health and sample scheduler
`timescale 1ns / 1ps

// Supervises one sensor channel; every input item is one tick of the channel.
// in_*  : tick items carrying the time in microseconds and the device answers
//         to init, trigger and read. in_tready is high whenever the result
//         register is empty or is being emptied in the same cycle.
// out_* : one result item per tick: the chosen action, its outcome, health,
//         status flags and the failure counters after the tick.
// cfg_* : register writes, always ready; write only while no tick is in flight.
//         Periods are scaled to microseconds when written.
// The result of a tick is registered and is on out_tdata in the cycle after acceptance.
// Throughput: one tick per cycle while results are taken, set by the single
// decision stage that updates the channel state and loads the result
// register at acceptance. A stalled receiver holds the result register;
// in_tready stays low until it is taken, and out_tdata holds steady meanwhile.
// Reset: health is not yet probed, counters, deadlines and flags are zero and
// the registers take their default values; the result register is empty.
module sensor_health_sample_scheduler_core
  import shss_pkg::*;
#(
  parameter int TIME_BITS   = 48,
  parameter int STREAK_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  // now_time, init_ok, trigger_ok, read_ok (lowest bit up), zero padded
  input  logic [((TIME_BITS+3+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // action, action_ok, was_reprobe, health, sample_is_valid, is_available,
  // went_missing, recovered, consecutive_count, total_count (lowest bit up)
  output logic [((RES_FLAGS_W+STREAK_BITS+TOTAL_W+7)/8)*8-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IN_W      = TIME_BITS + 3;
  localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W     = RES_FLAGS_W + STREAK_BITS + TOTAL_W;
  localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8;
  localparam int CMP_W     = (STREAK_BITS > 8) ? STREAK_BITS : 8;
  localparam logic [STREAK_BITS-1:0] STREAK_MAX = {STREAK_BITS{1'b1}};

  // configuration
  logic                    two_phase_r;
  logic [7:0]              thresh_r;
  logic [SAMPLE_US_W-1:0]  sample_us_r;
  logic [CONV_US_W-1:0]    conv_us_r;
  logic [FIRST_US_W-1:0]   first_us_r;
  logic [REPROBE_US_W-1:0] reprobe_us_r;

  // channel state
  logic [1:0]             health_r, health_nxt;
  logic                   await_r, await_nxt;
  logic [TIME_BITS-1:0]   sample_time_r, sample_time_nxt;
  logic [TIME_BITS-1:0]   conv_time_r, conv_time_nxt;
  logic [TIME_BITS-1:0]   probe_time_r, probe_time_nxt;
  logic [STREAK_BITS-1:0] streak_r, streak_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic                   valid_r, valid_nxt;
  logic                   present_r, present_nxt;

  // result register
  logic                out_valid_r;
  logic [OUT_TD_W-1:0] out_data_r, out_data_nxt;

  logic                   in_fire;
  logic [TIME_BITS-1:0]   now;
  logic                   init_ok, trig_ok, read_ok;
  logic [TIME_BITS-1:0]   dl_sample, dl_conv, dl_first, dl_reprobe;
  logic [STREAK_BITS-1:0] streak_inc;
  logic                   streak_ge;
  logic [1:0]             act;
  logic                   ok, reprobe, miss, recov, do_read, fail;

  // now plus a microsecond span, clamped at the top of the time range
  function automatic logic [TIME_BITS-1:0] deadline(input logic [TIME_BITS-1:0] t,
                                                    input logic [US_W-1:0] span);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, t} + (TIME_BITS+1)'(span);
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign now     = in_tdata[TIME_BITS-1:0];
  assign init_ok = in_tdata[TIME_BITS];
  assign trig_ok = in_tdata[TIME_BITS+1];
  assign read_ok = in_tdata[TIME_BITS+2];

  assign dl_sample  = deadline(now, US_W'(sample_us_r));
  assign dl_conv    = deadline(now, US_W'(conv_us_r));
  assign dl_first   = deadline(now, US_W'(first_us_r));
  assign dl_reprobe = deadline(now, US_W'(reprobe_us_r));

  assign streak_inc = (streak_r == STREAK_MAX) ? streak_r : streak_r + 1'b1;
  assign streak_ge  = CMP_W'(streak_inc) >= CMP_W'(thresh_r);

  always_comb begin
    health_nxt      = health_r;
    await_nxt       = await_r;
    sample_time_nxt = sample_time_r;
    conv_time_nxt   = conv_time_r;
    probe_time_nxt  = probe_time_r;
    streak_nxt      = streak_r;
    total_nxt       = total_r;
    valid_nxt       = valid_r;
    present_nxt     = present_r;
    act     = ACT_NONE;
    ok      = 1'b0;
    reprobe = 1'b0;
    miss    = 1'b0;
    recov   = 1'b0;
    do_read = 1'b0;
    fail    = 1'b0;

    if (health_r == H_UNPROBED || (health_r == H_MISSING && now >= probe_time_r)) begin
      reprobe     = (health_r == H_MISSING);
      act         = ACT_INIT;
      ok          = init_ok;
      valid_nxt   = 1'b0;
      streak_nxt  = '0;
      await_nxt   = 1'b0;
      present_nxt = init_ok;
      if (init_ok) begin
        health_nxt      = H_READY;
        probe_time_nxt  = '0;
        sample_time_nxt = dl_first;
      end else begin
        health_nxt      = H_MISSING;
        probe_time_nxt  = dl_reprobe;
        sample_time_nxt = '0;
      end
    end else if (health_r != H_MISSING) begin
      if (await_r) begin
        do_read = (now >= conv_time_r);
      end else if (now >= sample_time_r) begin
        if (two_phase_r) begin
          act = ACT_TRIGGER;
          ok  = trig_ok;
          if (trig_ok) begin
            await_nxt     = 1'b1;
            conv_time_nxt = dl_conv;
          end else begin
            fail            = 1'b1;
            sample_time_nxt = dl_sample;
          end
        end else begin
          do_read = 1'b1;
        end
      end

      if (do_read) begin
        act = ACT_READ;
        ok  = read_ok;
        if (read_ok) begin
          recov      = (health_r == H_DEGRADED);
          health_nxt = H_READY;
          valid_nxt  = 1'b1;
          streak_nxt = '0;
        end else begin
          fail = 1'b1;
        end
        await_nxt       = 1'b0;
        sample_time_nxt = dl_sample;
      end

      // trigger and read failures share the bookkeeping
      if (fail) begin
        valid_nxt  = 1'b0;
        total_nxt  = total_r + 1'b1;
        streak_nxt = streak_inc;
        if (streak_ge) begin
          health_nxt     = H_MISSING;
          probe_time_nxt = dl_reprobe;
          present_nxt    = 1'b0;
          miss           = 1'b1;
        end else begin
          health_nxt = H_DEGRADED;
        end
      end
    end

    out_data_nxt = OUT_TD_W'({total_nxt, streak_nxt, recov, miss, present_nxt, valid_nxt,
                              health_nxt, reprobe, ok, act});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_phase_r  <= 1'b0;
      thresh_r     <= RST_FAIL_THRESH;
      sample_us_r  <= RST_SAMPLE_US;
      conv_us_r    <= RST_CONV_US;
      first_us_r   <= RST_FIRST_US;
      reprobe_us_r <= RST_REPROBE_US;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TWO_PHASE:   two_phase_r  <= cfg_data[0];
        REG_SAMPLE_MS:   sample_us_r  <= SAMPLE_US_W'(cfg_data[15:0] * US_PER_MS);
        REG_CONV_MS:     conv_us_r    <= CONV_US_W'(cfg_data[9:0] * US_PER_MS);
        REG_FIRST_MS:    first_us_r   <= FIRST_US_W'(cfg_data[15:0] * US_PER_MS);
        REG_REPROBE_MS:  reprobe_us_r <= REPROBE_US_W'(cfg_data[19:0] * US_PER_MS);
        REG_FAIL_THRESH: thresh_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      health_r      <= H_UNPROBED;
      await_r       <= 1'b0;
      sample_time_r <= '0;
      conv_time_r   <= '0;
      probe_time_r  <= '0;
      streak_r      <= '0;
      total_r       <= '0;
      valid_r       <= 1'b0;
      present_r     <= 1'b0;
    end else if (in_fire) begin
      health_r      <= health_nxt;
      await_r       <= await_nxt;
      sample_time_r <= sample_time_nxt;
      conv_time_r   <= conv_time_nxt;
      probe_time_r  <= probe_time_nxt;
      streak_r      <= streak_nxt;
      total_r       <= total_nxt;
      valid_r       <= valid_nxt;
      present_r     <= present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // padding bits above the input fields carry nothing
  logic unused_in_pad;
  assign unused_in_pad = ^{1'b0, in_tdata[IN_TD_W-1:IN_W-1]};

endmodule

/* rtl/core/shss_checker.sv */
// port-level checks of the sensor health and sample scheduler, bound to the top level
`timescale 1ns / 1ps

module shss_checker
  import shss_pkg::*;
#(
  parameter int TIME_BITS   = 48,
  parameter int STREAK_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((RES_FLAGS_W+STREAK_BITS+TOTAL_W+7)/8)*8-1:0] out_tdata
);

  logic [1:0] act, health;
  logic       ok, reprobe, avail, miss, recov;

  assign act     = out_tdata[1:0];
  assign ok      = out_tdata[2];
  assign reprobe = out_tdata[3];
  assign health  = out_tdata[5:4];
  assign avail   = out_tdata[7];
  assign miss    = out_tdata[8];
  assign recov   = out_tdata[9];

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no action means no success and no reprobe
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && act == ACT_NONE |-> !ok && !reprobe)
    else $error("flags set without an action");

  // a reprobe is always an init
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && reprobe |-> act == ACT_INIT)
    else $error("reprobe flag on a non-init action");

  // recovery only from a good read, ending ready
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && recov |-> act == ACT_READ && ok && health == H_READY)
    else $error("recovered without a good read");

  // going missing leaves the channel missing and out of service
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && miss |-> health == H_MISSING && !avail && !ok)
    else $error("went missing with inconsistent status");

endmodule

bind sensor_health_sample_scheduler_core shss_checker #(
  .TIME_BITS  (TIME_BITS),
  .STREAK_BITS(STREAK_BITS)
) u_shss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* dv/sensor_health_sample_scheduler_core_test.sv */
// self-checking testbench for the sensor health and sample scheduler core
`timescale 1ns / 1ps

module sensor_health_sample_scheduler_core_test;
  import shss_pkg::*;

  localparam int TIME_W = 48;
  localparam int IN_W   = ((TIME_W + 3 + 7) / 8) * 8;
  localparam int OUT_W  = ((RES_FLAGS_W + 8 + TOTAL_W + 7) / 8) * 8;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  // indexes past the last register, the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // result item fields, lowest bit last
  typedef struct packed {
    logic [31:0] total_count;
    logic [7:0]  consecutive_count;
    logic        recovered;
    logic        went_missing;
    logic        is_available;
    logic        sample_is_valid;
    logic [1:0]  health;
    logic        was_reprobe;
    logic        action_ok;
    logic [1:0]  action;
  } verdict_t;

  class channel_health_tracker;
    // register copies
    bit          two_phase  = 1'b0;
    int unsigned sample_ms  = RST_SAMPLE_MS;
    int unsigned conv_ms    = RST_CONV_MS;
    int unsigned first_ms   = RST_FIRST_MS;
    int unsigned reprobe_ms = RST_REPROBE_MS;
    logic [7:0]  thresh     = RST_FAIL_THRESH;
    // channel state
    logic [1:0]        health     = H_UNPROBED;
    bit                converting = 1'b0;
    logic [TIME_W-1:0] sample_due = '0;
    logic [TIME_W-1:0] conv_due   = '0;
    logic [TIME_W-1:0] probe_due  = '0;
    logic [7:0]        streak     = '0;
    logic [31:0]       fail_total = '0;
    bit                sample_ok  = 1'b0;
    bit                present    = 1'b0;

    verdict_t    pending[$];
    int unsigned errors  = 0;
    int unsigned checked = 0;

    function logic [TIME_W-1:0] due_after(logic [TIME_W-1:0] t_now, int unsigned ms);
      logic [63:0] sum;
      sum = 64'(t_now) + 64'(ms) * 64'd1000;
      if (sum > 64'(TIME_TOP)) return TIME_TOP;
      return sum[TIME_W-1:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_TWO_PHASE:   two_phase = v[0];
        REG_SAMPLE_MS:   sample_ms = v[15:0];
        REG_CONV_MS:     conv_ms = v[9:0];
        REG_FIRST_MS:    first_ms = v[15:0];
        REG_REPROBE_MS:  reprobe_ms = v[19:0];
        REG_FAIL_THRESH: thresh = v[7:0];
        default: ;
      endcase
    endfunction

    // deadline that decides the next action, used to steer the time stamps
    function logic [TIME_W-1:0] next_due();
      if (health == H_UNPROBED) return '0;
      if (health == H_MISSING) return probe_due;
      if (converting) return conv_due;
      return sample_due;
    endfunction

    function bit count_failure(logic [TIME_W-1:0] t_now);
      sample_ok = 1'b0;
      fail_total = fail_total + 32'd1;
      if (streak != 8'hff) streak = streak + 8'd1;
      if (streak >= thresh) begin
        health = H_MISSING;
        probe_due = due_after(t_now, reprobe_ms);
        present = 1'b0;
        return 1'b1;
      end
      health = H_DEGRADED;
      return 1'b0;
    endfunction

    function void note_tick(logic [TIME_W-1:0] t_now, bit init_ok, bit trig_ok, bit read_ok);
      verdict_t v;
      bit do_read;
      v = '0;
      v.action = ACT_NONE;
      if (health == H_UNPROBED || (health == H_MISSING && t_now >= probe_due)) begin
        v.was_reprobe = (health == H_MISSING);
        v.action = ACT_INIT;
        v.action_ok = init_ok;
        sample_ok = 1'b0;
        streak = '0;
        converting = 1'b0;
        present = init_ok;
        if (init_ok) begin
          health = H_READY;
          probe_due = '0;
          sample_due = due_after(t_now, first_ms);
        end else begin
          health = H_MISSING;
          probe_due = due_after(t_now, reprobe_ms);
          sample_due = '0;
        end
      end else if (health != H_MISSING) begin
        do_read = 1'b0;
        if (converting) begin
          // the read follows a trigger even if the mode changed meanwhile
          do_read = (t_now >= conv_due);
        end else if (t_now >= sample_due) begin
          if (two_phase) begin
            v.action = ACT_TRIGGER;
            v.action_ok = trig_ok;
            if (trig_ok) begin
              converting = 1'b1;
              conv_due = due_after(t_now, conv_ms);
            end else begin
              v.went_missing = count_failure(t_now);
              sample_due = due_after(t_now, sample_ms);
            end
          end else begin
            do_read = 1'b1;
          end
        end
        if (do_read) begin
          v.action = ACT_READ;
          v.action_ok = read_ok;
          if (read_ok) begin
            v.recovered = (health == H_DEGRADED);
            health = H_READY;
            sample_ok = 1'b1;
            streak = '0;
          end else begin
            v.went_missing = count_failure(t_now);
          end
          converting = 1'b0;
          sample_due = due_after(t_now, sample_ms);
        end
      end
      v.health = health;
      v.sample_is_valid = sample_ok;
      v.is_available = present;
      v.consecutive_count = streak;
      v.total_count = fail_total;
      pending.push_back(v);
    endfunction

    function string show(verdict_t v);
      return $sformatf({"act=%0d ok=%0b reprobe=%0b health=%0d valid=%0b avail=%0b ",
                        "missing=%0b recov=%0b streak=%0d total=%0d"},
                       v.action, v.action_ok, v.was_reprobe, v.health, v.sample_is_valid,
                       v.is_available, v.went_missing, v.recovered, v.consecutive_count,
                       v.total_count);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("item %0d: result with no tick pending: %s", checked, show(got));
        return;
      end
      want = pending.pop_front();
      if (want.action != got.action || want.action_ok != got.action_ok ||
          want.was_reprobe != got.was_reprobe || want.health != got.health ||
          want.sample_is_valid != got.sample_is_valid ||
          want.is_available != got.is_available || want.went_missing != got.went_missing ||
          want.recovered != got.recovered ||
          want.consecutive_count != got.consecutive_count ||
          want.total_count != got.total_count) begin
        errors++;
        if (errors <= 10) begin
          $display("item %0d mismatch: expected %s", checked, show(want));
          $display("item %0d mismatch: actual   %s", checked, show(got));
        end
      end
    endfunction

    function bit clean();
      return errors == 0 && pending.size() == 0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic [IN_W-1:0] in_tdata;
  logic in_tvalid;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  channel_health_tracker tracker;
  logic [63:0] clock_now;
  int unsigned init_pct, trig_pct, read_pct;

  sensor_health_sample_scheduler_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(verdict_t'(out_tdata[49:0]));
  end

  // receiver stalls on a rotating pattern that is redrawn at regular intervals
  initial begin : stall_gen
    logic [15:0] pattern;
    int unsigned beat;
    out_tready = 1'b0;
    pattern = '1;
    beat = 0;
    forever begin
      @(posedge clk);
      if (beat % 48 == 0) begin
        case ($urandom_range(0, 2))
          0: pattern = '1;
          1: pattern = 16'($urandom) | 16'h0001;
          default: pattern = 16'($urandom & $urandom & $urandom) | 16'h8000;
        endcase
      end
      out_tready <= pattern[beat % 16];
      beat++;
    end
  end

  task automatic send_tick(logic [TIME_W-1:0] t_now, bit init_ok, bit trig_ok, bit read_ok);
    in_tdata <= {{(IN_W - TIME_W - 3){1'b0}}, read_ok, trig_ok, init_ok, t_now};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tracker.note_tick(t_now, init_ok, trig_ok, read_ok);
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, v);
  endtask

  // junk above the register width must be dropped by the block
  function automatic logic [31:0] padded(logic [31:0] v, int w);
    if ($urandom_range(0, 1)) return v | ($urandom << w);
    return v;
  endfunction

  task automatic set_regs(bit tp, int unsigned s, int unsigned c, int unsigned f,
                          int unsigned r, int unsigned th);
    write_reg(REG_TWO_PHASE, padded(32'(tp), 1));
    write_reg(REG_SAMPLE_MS, padded(s, 16));
    write_reg(REG_CONV_MS, padded(c, 10));
    write_reg(REG_FIRST_MS, padded(f, 16));
    write_reg(REG_REPROBE_MS, padded(r, 20));
    write_reg(REG_FAIL_THRESH, padded(th, 8));
    if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // time stamp steered toward the deadline that matters next
  function automatic logic [TIME_W-1:0] pick_time();
    logic [63:0] due, t, span;
    int unsigned r;
    due = 64'(tracker.next_due());
    if (due < clock_now) due = clock_now;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // step back in time, clock_now stays put
      if (clock_now > 64'd5000) return TIME_W'(clock_now - 64'($urandom_range(1, 5000)));
      return '0;
    end
    span = due - clock_now;
    if (span > 64'hffff_ffff) span = 64'hffff_ffff;
    if (r < 25) t = clock_now;
    else if (r < 45) t = clock_now + 64'($urandom_range(0, 32'(span)));
    else if (r < 75) t = due;
    else t = due + 64'($urandom_range(0, 3000));
    if (t > 64'(TIME_TOP)) t = 64'(TIME_TOP);
    clock_now = t;
    return t[TIME_W-1:0];
  endfunction

  task automatic run_ticks(int unsigned n);
    int unsigned burst;
    burst = $urandom_range(1, 30);
    for (int k = 0; k < n; k++) begin
      send_tick(pick_time(), $urandom_range(0, 99) < init_pct,
                $urandom_range(0, 99) < trig_pct, $urandom_range(0, 99) < read_pct);
      if ($urandom_range(0, 99) < 2) begin
        drain();
      end else begin
        burst = burst - 1;
        if (burst == 0) begin
          burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
          if ($urandom_range(0, 3) != 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        end
      end
    end
  endtask

  task automatic run_setting(int jump_bits, bit tp, int unsigned s, int unsigned c,
                             int unsigned f, int unsigned r, int unsigned th,
                             int unsigned ip, int unsigned tpct, int unsigned rp,
                             int unsigned n);
    drain();
    if (jump_bits >= TIME_W) clock_now = 64'(TIME_TOP) - 64'($urandom_range(0, 50_000_000));
    else clock_now = clock_now + ({$urandom, $urandom} & ((64'd1 << jump_bits) - 64'd1));
    set_regs(tp, s, c, f, r, th);
    init_pct = ip;
    trig_pct = tpct;
    read_pct = rp;
    run_ticks(n);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tracker = new();
    clock_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single read, 1000 ms period, 5000 ms reprobe, threshold 3
    send_tick(48'd0, 1'b0, 1'b1, 1'b1);          // first probe fails
    send_tick(48'd4_999_999, 1'b1, 1'b1, 1'b1);  // reprobe not yet due
    send_tick(48'd5_000_000, 1'b1, 1'b0, 1'b0);  // reprobe succeeds
    send_tick(48'd5_000_000, 1'b1, 1'b1, 1'b0);  // read fails, degraded
    send_tick(48'd5_999_999, 1'b0, 1'b0, 1'b0);
    send_tick(48'd6_000_000, 1'b0, 1'b0, 1'b1);  // recovery
    send_tick(48'd7_000_000, 1'b0, 1'b1, 1'b0);
    send_tick(48'd8_000_000, 1'b0, 1'b1, 1'b0);
    send_tick(48'd9_000_000, 1'b0, 1'b1, 1'b0);  // third failure goes missing
    send_tick(48'd8_000_000, 1'b1, 1'b1, 1'b1);  // time went back
    send_tick(48'd14_000_000, 1'b0, 1'b1, 1'b1); // reprobe fails
    send_tick(48'd19_000_000, 1'b1, 1'b0, 1'b0);
    drain();
    // two-phase with zero sample, conversion and reprobe periods and a zero threshold
    set_regs(1'b1, 0, 0, 7, 0, 0);
    send_tick(48'd19_000_000, 1'b0, 1'b1, 1'b0);
    send_tick(48'd19_000_000, 1'b0, 1'b0, 1'b1);
    send_tick(48'd19_000_000, 1'b0, 1'b0, 1'b1); // failed trigger goes missing at once
    send_tick(48'd19_000_000, 1'b1, 1'b0, 1'b0);
    send_tick(48'd19_006_999, 1'b1, 1'b1, 1'b1);
    send_tick(48'd19_007_000, 1'b0, 1'b1, 1'b0);
    drain();
    // pending conversion still ends in a read after leaving two-phase mode
    write_reg(REG_TWO_PHASE, '0);
    write_reg(REG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
    send_tick(48'd19_007_000, 1'b0, 1'b0, 1'b0);
    send_tick(48'd19_007_000, 1'b1, 1'b1, 1'b1);
    clock_now = 64'd19_007_000;

    run_setting(12, 1'b0, RST_SAMPLE_MS, RST_CONV_MS, RST_FIRST_MS, RST_REPROBE_MS,
                RST_FAIL_THRESH, 80, 85, 75, 145);
    run_setting(16, 1'b1, $urandom_range(1, 20), $urandom_range(0, 15), $urandom_range(0, 10),
                $urandom_range(1, 40), $urandom_range(1, 4), 80, 80, 70, 145);
    run_setting(20, 1'b1, 0, 0, 0, 0, 0, 70, 60, 60, 145);
    run_setting(24, 1'b0, 1, $urandom_range(0, 1023), 0, 1, 1, 75, 80, 60, 145);
    // every read fails, so the streak climbs to the top threshold
    run_setting(28, 1'b0, 0, $urandom_range(0, 1023), $urandom_range(0, 65535), 1, 255,
                95, 0, 0, 500);
    run_setting(32, 1'b1, 65535, 1023, 65535, 1048575, 255, 85, 85, 80, 145);
    run_setting(36, 1'($urandom), $urandom_range(1, 50), $urandom_range(0, 50),
                $urandom_range(0, 50), $urandom_range(1, 200), $urandom_range(1, 8),
                85, 80, 70, 145);
    run_setting(40, 1'($urandom), $urandom_range(0, 65535), $urandom_range(0, 1023),
                $urandom_range(0, 65535), $urandom_range(0, 1048575), $urandom_range(0, 255),
                85, 75, 70, 145);
    // close to the top of the time range, deadlines saturate
    run_setting(TIME_W, 1'($urandom), $urandom_range(20000, 65535), $urandom_range(0, 1023),
                $urandom_range(0, 65535), $urandom_range(0, 1048575), $urandom_range(1, 6),
                80, 80, 70, 145);

    drain();
    repeat (4) @(posedge clk);
    if (tracker.clean()) begin
      $display("sensor_health_sample_scheduler_core_test: done, clean");
    end else begin
      $display("sensor_health_sample_scheduler_core_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("sensor_health_sample_scheduler_core_test: done, errors");
    $finish;
  end

endmodule
